// ===== rtl/core/qdp_pkg.sv =====
// Package for the int8 quantized dot-product block: widths, register
// indexes, reset values, shared types and saturation constants.
// No dependencies; imported by every module under rtl/core but qdp_fifo.
package qdp_pkg;

    // Default accumulator width, handed down from the top level
    localparam int ACC_BITS_DEF = 32;

    // Field widths
    localparam int ACT_W     = 16;
    localparam int WGT_W     = 8;
    localparam int BIAS_W    = 32;
    localparam int RES_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int TERM_W    = 18;   // 9b x 9b signed product

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // int8 saturation limits
    localparam logic signed [7:0] Q_MIN = -8'sd128;
    localparam logic signed [7:0] Q_MAX = 8'sd127;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_INV_SCALE = 3'd0,
        CFG_IN_ZP        = 3'd1,
        CFG_WT_ZP        = 3'd2,
        CFG_DQ_SCALE     = 3'd3,
        CFG_RELU_EN      = 3'd4
    } t_cfg_index;

    // Register reset values
    localparam logic [31:0] RST_IN_INV_SCALE = 32'd65536;
    localparam logic [31:0] RST_DQ_SCALE     = 32'd65536;

    // Register bank contents
    typedef struct packed {
        logic [31:0]        iis;       // input inverse scale, Q16.16
        logic signed [7:0]  izp;       // input zero point
        logic signed [7:0]  wzp;       // weight zero point
        logic [31:0]        dq_scale;  // dequant scale, Q0.32
        logic               relu;      // clamp negatives to zero
    } t_cfg;

    // One queued request from front to back
    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        logic signed [BIAS_W-1:0] bias;
        logic                     last;
    } t_mac_item;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ROUND,
        BK_FINISH
    } t_back_state;

endpackage

// ===== rtl/core/qdp_fifo.sv =====
// Small register FIFO carrying requests from the front to the back.
// Depends on nothing but its parameters.
module qdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/qdp_front.sv =====
// Front end: accepts input requests, quantizes the activation to int8 and
// forms the zero-point corrected product in three stages. Uses qdp_pkg.
module qdp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qdp_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [qdp_pkg::ACT_W-1:0]  i_activation,
    input  logic signed [qdp_pkg::WGT_W-1:0]  i_weight,
    input  logic signed [qdp_pkg::BIAS_W-1:0] i_bias,
    input  logic                          i_last,
    output logic                          o_push,
    output qdp_pkg::t_mac_item            o_item,
    input  logic                          i_full
);
    import qdp_pkg::*;

    // Stage registers
    logic                     r1_v, r2_v, r3_v;
    logic signed [48:0]       r1_prod;
    logic signed [7:0]        r1_w;
    logic signed [BIAS_W-1:0] r1_bias, r2_bias;
    logic                     r1_last, r2_last;
    logic signed [7:0]        r2_q;
    logic signed [8:0]        r2_wd;
    t_mac_item                r3_item;

    logic                     adv;
    logic signed [48:0]       s1_prod;
    logic signed [49:0]       s2_t, s2_rnd;
    logic signed [25:0]       s2_qpre;
    logic signed [7:0]        s2_q;
    logic signed [8:0]        s2_wd, s3_qd;
    t_mac_item                s3_item;

    // Whole pipe moves unless the last stage is blocked by a full queue
    assign adv     = !(r3_v && i_full);
    assign o_ready = adv;
    assign o_push  = r3_v && !i_full;
    assign o_item  = r3_item;

    // Stage 1: activation times inverse scale (Q8.8 x Q16.16 = Q.24)
    assign s1_prod = i_activation * $signed({1'b0, i_cfg.iis});

    // Stage 2: add zero point, round half away from zero, saturate to int8
    always_comb begin
        s2_t    = {r1_prod[48], r1_prod} + {{18{i_cfg.izp[7]}}, i_cfg.izp, 24'b0};
        s2_rnd  = s2_t + (50'sd1 <<< 23) - {49'b0, s2_t[49]};
        s2_qpre = s2_rnd[49:24];
        if (s2_qpre[25:7] == {19{s2_qpre[25]}}) begin
            s2_q = s2_qpre[7:0];
        end else begin
            s2_q = s2_qpre[25] ? Q_MIN : Q_MAX;
        end
        s2_wd = {r1_w[7], r1_w} - {i_cfg.wzp[7], i_cfg.wzp};
    end

    // Stage 3: zero-point corrected product
    always_comb begin
        s3_qd        = {r2_q[7], r2_q} - {i_cfg.izp[7], i_cfg.izp};
        s3_item.term = s3_qd * r2_wd;
        s3_item.bias = r2_bias;
        s3_item.last = r2_last;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_prod <= s1_prod;
            r1_w    <= i_weight;
            r1_bias <= i_bias;
            r1_last <= i_last;
            r2_q    <= s2_q;
            r2_wd   <= s2_wd;
            r2_bias <= r1_bias;
            r2_last <= r1_last;
            r3_item <= s3_item;
        end
    end

endmodule

// ===== rtl/core/qdp_back.sv =====
// Back end: accumulates queued products and, on the last element,
// dequantizes, adds bias, saturates and applies ReLU when enabled. Uses qdp_pkg.
module qdp_back #(
    parameter int ACC_BITS = qdp_pkg::ACC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  qdp_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    input  qdp_pkg::t_mac_item             i_item,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [qdp_pkg::RES_W-1:0]      o_out_data
);
    import qdp_pkg::*;

    localparam int NCH    = (ACC_BITS + 15) / 16;          // 16-bit chunks of |acc|
    localparam int MAG_W  = NCH * 16;
    localparam int PROD_W = MAG_W + 32;
    localparam int P_W    = PROD_W - 16;
    localparam int CNT_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << 15;
    localparam logic [34:0]       P_CAP = 35'(1) << 34;

    t_back_state         r_state, n_state;
    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic                r_neg, n_neg;
    logic signed [BIAS_W-1:0] r_bias, n_bias;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [34:0]         r_p, n_p;
    logic                r_out_valid, n_out_valid;
    logic [RES_W-1:0]    r_out_data, n_out_data;

    logic [ACC_BITS-1:0] acc_sum, acc_mag;
    logic [47:0]         pp;
    logic [PROD_W-1:0]   rnd;
    logic [P_W-1:0]      p_full;
    logic signed [36:0]  p_s, v;
    logic [RES_W-1:0]    res;
    logic                out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || i_out_ready;

    // Datapath terms
    always_comb begin
        acc_sum = r_acc + {{(ACC_BITS - TERM_W){i_item.term[TERM_W-1]}}, i_item.term};
        acc_mag = acc_sum[ACC_BITS-1] ? (~acc_sum + 1'b1) : acc_sum;
        pp      = 48'(r_mag[MAG_W-1 -: 16]) * 48'(i_cfg.dq_scale);
        rnd     = r_prod + HALF;
        p_full  = rnd[PROD_W-1:16];
        p_s     = {2'b0, r_p};
        v       = (r_neg ? -p_s : p_s) + {{5{r_bias[BIAS_W-1]}}, r_bias};
        if (v[36:31] == {6{v[36]}}) begin
            res = v[31:0];
        end else begin
            res = v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (i_cfg.relu && res[31]) begin
            res = '0;
        end
    end

    // Sequencer: next state and register updates
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bias      = r_bias;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_p         = r_p;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            BK_IDLE: begin
                o_pop = i_valid;
                if (i_valid) begin
                    if (i_item.last) begin
                        n_neg   = acc_sum[ACC_BITS-1];
                        n_mag   = MAG_W'(acc_mag);
                        n_bias  = i_item.bias;
                        n_acc   = '0;
                        n_prod  = '0;
                        n_cnt   = '0;
                        n_state = BK_MUL;
                    end else begin
                        n_acc = acc_sum;
                    end
                end
            end
            BK_MUL: begin
                // Horner step: top chunk first
                n_prod = (r_prod << 16) + PROD_W'(pp);
                n_mag  = r_mag << 16;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NCH - 1)) begin
                    n_state = BK_ROUND;
                end
            end
            BK_ROUND: begin
                n_p     = (p_full > P_W'(P_CAP)) ? P_CAP : p_full[34:0];
                n_state = BK_FINISH;
            end
            BK_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = res;
                    n_state     = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_bias     <= n_bias;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_p        <= n_p;
        r_out_data <= n_out_data;
    end

endmodule

// ===== rtl/core/quantized_int8_dot_product.sv =====
// Top level of the int8 quantized dot-product block: register bank, front
// end, request queue and back end. Uses qdp_pkg, qdp_front, qdp_fifo, qdp_back.
//
//  channel   signals                         payload
//  --------  ------------------------------  ---------------------------------
//  input     s_axis_tvalid/tready            tdata: activation, weight, bias
//            s_axis_tdata/tlast              tlast: last element
//  output    m_axis_tvalid/tready/tdata      tdata: result_value
//  config    i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// The front end takes one request per cycle, unless a full queue stalls it,
// through a three-stage pipe into a four-entry queue. The back end retires
// a non-last element as it pops it; a last element holds it through the
// 16x32 multiply sequence over the accumulator magnitude, rounding and
// bias (BK_MUL, BK_ROUND, BK_FINISH).
// Reset is synchronous, active low, and clears the accumulator and pipes.
// A stalled result stays in the output register; the queue absorbs the rest.
module quantized_int8_dot_product #(
    parameter int ACC_BITS = qdp_pkg::ACC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] activation, [23:16] weight_value, [55:24] bias_value
    input  logic [55:0]                       s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] result_value
    output logic [qdp_pkg::RES_W-1:0]         m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qdp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qdp_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import qdp_pkg::*;

    localparam int ITEM_W = $bits(t_mac_item);

    t_cfg              r_cfg;
    logic              push, pop, q_valid, q_full;
    t_mac_item         push_item, pop_item;
    logic [ITEM_W-1:0] pop_bits;

    assign o_cfg_ready = 1'b1;
    assign pop_item    = t_mac_item'(pop_bits);

    // Register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iis      <= RST_IN_INV_SCALE;
            r_cfg.izp      <= '0;
            r_cfg.wzp      <= '0;
            r_cfg.dq_scale <= RST_DQ_SCALE;
            r_cfg.relu     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_INV_SCALE: r_cfg.iis      <= i_cfg_data[31:0];
                CFG_IN_ZP:        r_cfg.izp      <= i_cfg_data[7:0];
                CFG_WT_ZP:        r_cfg.wzp      <= i_cfg_data[7:0];
                CFG_DQ_SCALE:     r_cfg.dq_scale <= i_cfg_data[31:0];
                CFG_RELU_EN:      r_cfg.relu     <= i_cfg_data[0];
                default:          r_cfg          <= r_cfg;
            endcase
        end
    end

    qdp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_activation (s_axis_tdata[15:0]),
        .i_weight     (s_axis_tdata[23:16]),
        .i_bias       (s_axis_tdata[55:24]),
        .i_last       (s_axis_tlast),
        .o_push       (push),
        .o_item       (push_item),
        .i_full       (q_full)
    );

    qdp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_data  (pop_bits),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    qdp_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_item      (pop_item),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/qdp_checker.sv =====
// Port-level checks for the int8 quantized dot-product block, bound to the
// top level. Uses qdp_pkg for widths.
module qdp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      s_axis_tlast,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [qdp_pkg::RES_W-1:0] m_axis_tdata
);
    import qdp_pkg::*;

    logic       in_last_acc, out_acc;
    logic [3:0] r_pending;

    assign in_last_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_acc     = m_axis_tvalid && m_axis_tready;

    // Last-element requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {3'b0, in_last_acc} - {3'b0, out_acc};
        end
    end

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Every result answers an earlier last-element request
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != '0))
        else $error("result without a pending last element");

    // The pending count never reaches 4'hF, the top of its four-bit range
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 4'hF)
        else $error("pending count out of range");

endmodule

bind quantized_int8_dot_product qdp_checker u_qdp_checker (.*);

// ===== tb/qdp_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for quantized_int8_dot_product: watches the request, config
// and result channels, predicts every dot-product result and compares in order.
// Depends on qdp_pkg for field widths, register indexes and the int8 limits.
module qdp_result_checker
    import qdp_pkg::*;
#(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [15:0] activation, [23:16] weight_value, [55:24] bias_value
    input  logic [ACT_W+WGT_W+BIAS_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] result_value
    input  logic [RES_W-1:0]               i_m_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DAT_W-1:0]           i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);

    localparam int              WGT_LSB     = ACT_W;
    localparam int              BIAS_LSB    = ACT_W + WGT_W;
    localparam int              QUANT_FRAC  = 24;   // Q8.8 times Q16.16 gives Q.24
    localparam int              DQ_SHIFT    = 16;   // Q0.32 scale, result in Q16.16
    localparam longint unsigned DQ_CLAMP    = 64'd1 << 34;
    localparam longint          RES_MAX     = 64'sd2147483647;
    localparam longint          RES_MIN     = -64'sd2147483648;
    localparam int              MAX_REPORTS = 30;

    t_cfg                  cfg;
    logic [ACC_BITS-1:0]   dot_total;
    logic [RES_W-1:0]      expected_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // One line per mismatch, quiet after the first few, always counted
    task automatic report_mismatch(input string what);
        if (o_errors < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, what);
        o_errors++;
    endtask

    // Activation to int8: exact Q.24 value, round half away from zero, saturate
    function automatic logic signed [WGT_W-1:0] quantize_act(
        input logic signed [ACT_W-1:0] act
    );
        longint          scaled;
        longint unsigned mag;
        longint          rounded;
        scaled  = longint'(act) * longint'({32'd0, cfg.iis})
                + (longint'($signed(cfg.izp)) <<< QUANT_FRAC);
        mag     = (scaled < 0) ? -scaled : scaled;
        mag     = (mag + (64'd1 << (QUANT_FRAC - 1))) >> QUANT_FRAC;
        rounded = (scaled < 0) ? -longint'(mag) : longint'(mag);
        if (rounded < Q_MIN)
            return Q_MIN;
        if (rounded > Q_MAX)
            return Q_MAX;
        return WGT_W'(rounded);
    endfunction

    // Dequantize the sum, add bias, saturate to Q16.16, optional ReLU
    function automatic logic [RES_W-1:0] neuron_output(
        input logic [ACC_BITS-1:0]      total,
        input logic signed [BIAS_W-1:0] bias
    );
        longint          acc;
        longint unsigned mag;
        longint unsigned prod;
        longint          val;
        acc  = longint'($signed(total));
        mag  = (acc < 0) ? -acc : acc;
        // split multiply keeps the exact product; only the low half is rounded
        prod = mag * cfg.dq_scale[31:16]
             + ((mag * cfg.dq_scale[15:0] + (64'd1 << (DQ_SHIFT - 1))) >> DQ_SHIFT);
        if (prod > DQ_CLAMP)
            prod = DQ_CLAMP;
        val = (acc < 0) ? -longint'(prod) : longint'(prod);
        val = val + longint'(bias);
        if (val > RES_MAX)
            val = RES_MAX;
        if (val < RES_MIN)
            val = RES_MIN;
        if (cfg.relu && val < 0)
            val = 0;
        return RES_W'(val);
    endfunction

    always @(posedge i_clk) begin
        logic signed [ACT_W-1:0]  act;
        logic signed [WGT_W-1:0]  wgt;
        logic signed [BIAS_W-1:0] bias;
        logic signed [WGT_W-1:0]  q_act;
        longint                   term;
        logic [RES_W-1:0]         want;
        if (!i_rst_n) begin
            cfg.iis      = RST_IN_INV_SCALE;
            cfg.izp      = '0;
            cfg.wzp      = '0;
            cfg.dq_scale = RST_DQ_SCALE;
            cfg.relu     = 1'b0;
            dot_total    = '0;
            expected_results.delete();
        end else begin
            // Results first; none can stem from a request taken at this edge
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with none expected", i_m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (i_m_tdata !== want)
                        report_mismatch($sformatf("result_value %h, expected %h",
                                                  i_m_tdata, want));
                end
            end

            // Register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IN_INV_SCALE: cfg.iis      = i_cfg_data;
                    CFG_IN_ZP:        cfg.izp      = i_cfg_data[WGT_W-1:0];
                    CFG_WT_ZP:        cfg.wzp      = i_cfg_data[WGT_W-1:0];
                    CFG_DQ_SCALE:     cfg.dq_scale = i_cfg_data;
                    CFG_RELU_EN:      cfg.relu     = i_cfg_data[0];
                    default: ;
                endcase
            end

            // MAC step; a last element closes the neuron
            if (i_s_tvalid && i_s_tready) begin
                act   = i_s_tdata[ACT_W-1:0];
                wgt   = i_s_tdata[WGT_LSB +: WGT_W];
                bias  = i_s_tdata[BIAS_LSB +: BIAS_W];
                q_act = quantize_act(act);
                term  = (longint'(q_act) - longint'($signed(cfg.izp)))
                      * (longint'(wgt) - longint'($signed(cfg.wzp)));
                dot_total = dot_total + ACC_BITS'(term);
                if (i_s_tlast) begin
                    expected_results.push_back(neuron_output(dot_total, bias));
                    dot_total = '0;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/quantized_int8_dot_product_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for quantized_int8_dot_product: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on qdp_pkg, the block's RTL and qdp_result_checker.
module quantized_int8_dot_product_tb;
    import qdp_pkg::*;

    localparam int ACC_BITS        = ACC_BITS_DEF;
    localparam int PAYLOAD_W       = ACT_W + WGT_W + BIAS_W;
    localparam int CLK_HALF        = 1;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 20;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RUN_LIMIT_NS    = 4000000;
    localparam int LONG_TERMS      = 16;      // 128*255 per term, sum near 2^19
    localparam int CLAMP_TERMS     = 5;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 84;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_RUNS
    } t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [15:0] activation, [23:16] weight_value, [55:24] bias_value
    logic [PAYLOAD_W-1:0]   s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] result_value
    logic [RES_W-1:0]       m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DAT_W-1:0]   i_cfg_data;

    int                     mismatches;
    int                     pending;
    int                     checked;
    int                     burst_left = 0;
    int                     gap_max = 0;
    int                     requests_sent = 0;
    int                     directed_sent = 0;
    int                     settings_used = 0;
    logic [11:0]            rx_cycle = '0;
    int                     rx_run = 0;

    quantized_int8_dot_product #(.ACC_BITS(ACC_BITS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    qdp_result_checker #(.ACC_BITS(ACC_BITS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mismatches),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hang guard
    initial begin
        #RUN_LIMIT_NS;
        $display("timeout: run did not complete");
        $display("RESULT: ERROR");
        $finish;
    end

    // Result back-pressure: mode rotates with rx_cycle[11:10]
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (t_rx_mode'(rx_cycle[11:10]))
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_axis_tready <= ($urandom_range(0, 9) < 3);
            default: begin
                // alternating runs of ready and stall
                if (rx_run == 0) begin
                    rx_run = $urandom_range(1, 16);
                    m_axis_tready <= ~m_axis_tready;
                end else begin
                    rx_run--;
                end
            end
        endcase
    end

    // One input request; bursts of random length, gaps up to gap_max
    task automatic send_request(input logic signed [ACT_W-1:0]  act,
                                input logic signed [WGT_W-1:0]  wgt,
                                input logic signed [BIAS_W-1:0] bias,
                                input logic                     is_last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bias, wgt, act};
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // One register request; valid stays up for back-to-back writes
    task automatic cfg_request(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Full register set, junk in unused upper bits, then unmapped indexes
    task automatic write_regs(input logic [31:0]       iis,
                              input logic signed [7:0] izp,
                              input logic signed [7:0] wzp,
                              input logic [31:0]       dq,
                              input logic              relu);
        cfg_request(CFG_IN_INV_SCALE, iis);
        cfg_request(CFG_IN_ZP, {24'($urandom), izp});
        cfg_request(CFG_WT_ZP, {24'($urandom), wzp});
        cfg_request(CFG_DQ_SCALE, dq);
        cfg_request(CFG_RELU_EN, {31'($urandom), relu});
        for (int idx = int'(CFG_RELU_EN) + 1; idx < (1 << CFG_IDX_W); idx++)
            cfg_request(CFG_IDX_W'(idx), $urandom);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Stop sending and let the pipe empty before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic signed [ACT_W-1:0] pick_act();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return ACT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [BIAS_W-1:0] pick_bias();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            1, 2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    initial begin
        int waited;
        int left;
        int run_len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IN_INV_SCALE;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: activation saturation, rounding of halves,
        // output saturation both ways, bias ignored on non-last elements
        send_request(16'sh7fff, 8'sh7f, 32'sh0000_0000, 1'b0);
        send_request(16'sh8000, 8'sh80, 32'sh0000_0000, 1'b0);
        send_request(16'sh0080, 8'sh01, 32'sh0000_0000, 1'b0);
        send_request(16'shff80, 8'sh01, 32'sh0000_0000, 1'b0);
        send_request(16'sh007f, 8'sh01, 32'sh7fff_ffff, 1'b1);
        send_request(16'sh8000, 8'sh7f, 32'sh8000_0000, 1'b1);
        send_request(16'sh0000, 8'sh00, 32'sh0000_0000, 1'b1);
        send_request(16'sh0100, 8'sh02, 32'sh7654_3210, 1'b0);
        send_request(16'shff00, 8'sh03, 32'sh0000_8000, 1'b1);
        settle();

        // Largest scales, opposite zero points: negative sums, product clamp
        write_regs(32'hffff_ffff, -8'sd128, 8'sd127, 32'hffff_ffff, 1'b0);
        send_request(16'sh0001, 8'sh80, 32'sh0000_0000, 1'b1);
        for (int k = 0; k < CLAMP_TERMS; k++)
            send_request(16'sh7fff, 8'sh80, 32'sh7fff_ffff, k == CLAMP_TERMS - 1);
        settle();

        // Zero scales with ReLU: result is the bias, clamped at zero
        write_regs(32'h0000_0000, 8'sd127, -8'sd128, 32'h0000_0000, 1'b1);
        send_request(16'sh1234, 8'sh55, 32'sh8000_0000, 1'b1);
        send_request(16'sh7fff, 8'sh7f, 32'sh7fff_ffff, 1'b1);
        settle();
        directed_sent = requests_sent;

        // Long neuron, every term 128*255, for a large positive sum
        write_regs(32'd65536, -8'sd128, -8'sd128, 32'd65536, 1'b0);
        for (int k = 0; k < LONG_TERMS; k++)
            send_request(16'sh7fff, 8'sh7f, pick_bias(), k == LONG_TERMS - 1);
        settle();

        // Random settings and neurons of random length
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_regs(pick_scale(), 8'($urandom), 8'($urandom), pick_scale(),
                       1'($urandom));
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                run_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
                if (run_len > left)
                    run_len = left;
                for (int k = 0; k < run_len; k++)
                    send_request(pick_act(), WGT_W'($urandom), pick_bias(),
                                 k == run_len - 1);
                left -= run_len;
            end
            if (ph < RANDOM_PHASES - 1)
                settle();
        end

        // Drain and verdict
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending != 0) begin
            $display("timeout: %0d results never arrived", pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            $display("Sent %0d requests (%0d directed, %0d in the long neuron), %0d results checked",
                     requests_sent, directed_sent, LONG_TERMS, checked);
            $display("Used %0d register settings incl. zero and all-ones scales, %0d mismatches",
                     settings_used, mismatches);
            if (mismatches == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
